FILE: src/hsi2_pkg.sv
// Shared widths, types and codes of the 2D Hermite spline interpolator.
package hsi2_pkg;

  // Point and position formats.
  localparam int COORD_BITS    = 32;
  localparam int POS_FRAC_BITS = 16;
  localparam int POS_W         = POS_FRAC_BITS + 1;

  // Configuration port and tension/bias format (signed Q1.14).
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int Q14_FRAC  = 14;
  localparam int FACT_W    = Q14_FRAC + 2;
  localparam int WGT_W     = 2 * FACT_W - 1;
  localparam int WGT_SHIFT = 2 * Q14_FRAC + 1;

  // Datapath widths.
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int TPROD_W = DIFF_W + WGT_W + 1;
  localparam int TAN_W   = COORD_BITS + 3;
  localparam int H_W     = POS_W + 2;
  localparam int PP_W    = COORD_BITS + H_W;
  localparam int MP_W    = TAN_W + H_W;
  localparam int ACC_W   = MP_W + 2;
  localparam int RND_W   = ACC_W - POS_FRAC_BITS;

  localparam int NUM_STAGES = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TENSION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS    = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [H_W-1:0]        basis_t;
  typedef logic [WGT_W-1:0]             weight_t;

  // Per-stage load enables handed from the control to each axis datapath.
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } hsi2_ctl_t;

endpackage

FILE: src/hsi2_if.sv
// Request and result channel interfaces of the Hermite spline interpolator.
interface hsi2_in_if
  import hsi2_pkg::*;
();
  logic             valid;
  logic             ready;
  coord_t           p1_x;
  coord_t           p1_y;
  coord_t           p2_x;
  coord_t           p2_y;
  coord_t           p3_x;
  coord_t           p3_y;
  coord_t           p4_x;
  coord_t           p4_y;
  logic [POS_W-1:0] position;

  modport source (output valid, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y,
                  position, input ready);
  modport sink (input valid, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y,
                position, output ready);
endinterface

interface hsi2_out_if
  import hsi2_pkg::*;
();
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  logic   saturated;

  modport source (output valid, out_x, out_y, saturated, input ready);
  modport sink (input valid, out_x, out_y, saturated, output ready);
endinterface

FILE: src/hsi2_axis.sv
// One coordinate axis: tangents, weighted Hermite sum, rounding and saturation.
module hsi2_axis
  import hsi2_pkg::*;
(
  input  logic      clk,
  input  hsi2_ctl_t ctl,
  input  coord_t    p1,
  input  coord_t    p2,
  input  coord_t    p3,
  input  coord_t    p4,
  input  weight_t   wa,
  input  weight_t   wb,
  input  basis_t    h00,
  input  basis_t    h10,
  input  basis_t    h01,
  input  basis_t    h11,
  output coord_t    res,
  output logic      sat
);

  localparam logic signed [TPROD_W-1:0] TAN_HALF =
    TPROD_W'(64'd1 << (WGT_SHIFT - 1));
  localparam logic signed [ACC_W-1:0] ACC_HALF =
    ACC_W'(64'd1 << (POS_FRAC_BITS - 1));
  localparam coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Stage 1: segment differences.
  logic signed [DIFF_W-1:0] da_1_r, db_1_r, dc_1_r;
  coord_t                   p2_1_r, p3_1_r;

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      da_1_r <= {p2[COORD_BITS-1], p2} - {p1[COORD_BITS-1], p1};
      db_1_r <= {p3[COORD_BITS-1], p3} - {p2[COORD_BITS-1], p2};
      dc_1_r <= {p4[COORD_BITS-1], p4} - {p3[COORD_BITS-1], p3};
      p2_1_r <= p2;
      p3_1_r <= p3;
    end
  end

  // Stage 2: difference times tangent weight, four products.
  logic signed [WGT_W:0]    wa_s, wb_s;
  logic signed [TPROD_W-1:0] pa1_nxt, pb1_nxt, pa2_nxt, pb2_nxt;
  logic signed [TPROD_W-1:0] pa1_2_r, pb1_2_r, pa2_2_r, pb2_2_r;
  coord_t                    p2_2_r, p3_2_r;

  assign wa_s    = {1'b0, wa};
  assign wb_s    = {1'b0, wb};
  assign pa1_nxt = da_1_r * wa_s;
  assign pb1_nxt = db_1_r * wb_s;
  assign pa2_nxt = db_1_r * wa_s;
  assign pb2_nxt = dc_1_r * wb_s;

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      pa1_2_r <= pa1_nxt;
      pb1_2_r <= pb1_nxt;
      pa2_2_r <= pa2_nxt;
      pb2_2_r <= pb2_nxt;
      p2_2_r  <= p2_1_r;
      p3_2_r  <= p3_1_r;
    end
  end

  // Stage 3: sum the products and round each tangent to the point format.
  logic signed [TPROD_W-1:0] m1_sum, m2_sum;
  logic signed [TAN_W-1:0]   m1_3_r, m2_3_r;
  coord_t                    p2_3_r, p3_3_r;

  assign m1_sum = pa1_2_r + pb1_2_r + TAN_HALF;
  assign m2_sum = pa2_2_r + pb2_2_r + TAN_HALF;

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      m1_3_r <= m1_sum[WGT_SHIFT +: TAN_W];
      m2_3_r <= m2_sum[WGT_SHIFT +: TAN_W];
      p2_3_r <= p2_2_r;
      p3_3_r <= p3_2_r;
    end
  end

  // Stage 4: weight each term by its basis function.
  logic signed [PP_W-1:0] q0_nxt, q3_nxt, q0_4_r, q3_4_r;
  logic signed [MP_W-1:0] q1_nxt, q2_nxt, q1_4_r, q2_4_r;

  assign q0_nxt = p2_3_r * h00;
  assign q1_nxt = m1_3_r * h10;
  assign q2_nxt = m2_3_r * h01;
  assign q3_nxt = p3_3_r * h11;

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      q0_4_r <= q0_nxt;
      q1_4_r <= q1_nxt;
      q2_4_r <= q2_nxt;
      q3_4_r <= q3_nxt;
    end
  end

  // Stage 5: exact sum of the four terms plus the rounding half.
  logic signed [ACC_W-1:0] acc_nxt, acc_5_r;

  assign acc_nxt = {{(ACC_W-PP_W){q0_4_r[PP_W-1]}}, q0_4_r}
                 + {{(ACC_W-MP_W){q1_4_r[MP_W-1]}}, q1_4_r}
                 + {{(ACC_W-MP_W){q2_4_r[MP_W-1]}}, q2_4_r}
                 + {{(ACC_W-PP_W){q3_4_r[PP_W-1]}}, q3_4_r}
                 + ACC_HALF;

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      acc_5_r <= acc_nxt;
    end
  end

  // Stage 6: drop the fraction and clip to the coordinate range.
  logic signed [RND_W-1:0] rnd;
  logic                    ovf;
  coord_t                  res_nxt, res_6_r;
  logic                    sat_6_r;

  assign rnd = acc_5_r[POS_FRAC_BITS +: RND_W];
  assign ovf = !((&rnd[RND_W-1:COORD_BITS-1]) || !(|rnd[RND_W-1:COORD_BITS-1]));

  always_comb begin
    if (ovf) begin
      res_nxt = rnd[RND_W-1] ? CMIN : CMAX;
    end else begin
      res_nxt = rnd[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[5]) begin
      res_6_r <= res_nxt;
      sat_6_r <= ovf;
    end
  end

  assign res = res_6_r;
  assign sat = sat_6_r;

endmodule

FILE: src/hermite_spline_interp_2d_unit.sv
// Top level of the 2D Hermite spline interpolator with tension and bias.
//
// Usage: a request on in_req carries four control points p1..p4 (signed
// Q16.16) and a position t (unsigned Q1.16, 65536 is 1.0, larger values
// clip to 1.0). The result on out_rsp is the point on the segment from p2
// to p3, rounded to nearest and clipped to the coordinate range; saturated
// flags a clip on either axis. Tension and bias are written through the
// cfg_ port (index 0 tension, index 1 bias, signed Q1.14, clipped to
// [-1.0, 1.0] on use) while no request is in flight.
// Pipeline: six register stages; a request accepted at one clock edge has
// its result offered once it has been registered through all six.
// Throughput: one request per cycle unless the receiver stalls; depth is
// set by the multiplier stages of the tangent and basis products.
// Reset clears tension and bias to zero and empties the pipeline; the
// request side is not ready while rst_n is low.
// When the receiver stalls, each stage holds until the one after it frees
// up, so empty stages keep filling and requests are taken until the whole
// pipeline is full. Nothing is dropped or repeated.
module hermite_spline_interp_2d_unit
  import hsi2_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  hsi2_in_if.sink              in_req,
  hsi2_out_if.source           out_rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam logic signed [CFG_W:0] Q14_ONE_S = (CFG_W+1)'(1 << Q14_FRAC);
  localparam logic signed [CFG_W:0] Q14_MONE_S = -Q14_ONE_S;
  localparam weight_t WGT_RESET = WGT_W'(64'd1 << (2 * Q14_FRAC));
  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1 << POS_FRAC_BITS);
  localparam logic [2*POS_W-1:0] POS_HALF = (2*POS_W)'(1 << (POS_FRAC_BITS - 1));
  localparam basis_t H_ONE = H_W'(1 << POS_FRAC_BITS);

  // Configuration registers.
  logic [CFG_W-1:0] tension_r, bias_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tension_r <= '0;
      bias_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TENSION: tension_r <= cfg_wdata;
        CFG_BIAS:    bias_r    <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // Tangent weights (1+b)(1-s) and (1-b)(1-s), kept registered.
  function automatic logic signed [CFG_W:0] clamp_q14(input logic [CFG_W-1:0] v);
    logic signed [CFG_W:0] e;
    e = {v[CFG_W-1], v};
    if (e > Q14_ONE_S) begin
      return Q14_ONE_S;
    end else if (e < Q14_MONE_S) begin
      return Q14_MONE_S;
    end
    return e;
  endfunction

  logic signed [CFG_W:0]   ten_c, bias_c, ft_s, fa_s, fb_s;
  logic [2*FACT_W-1:0]     wa_full, wb_full;
  weight_t                 wa_r, wb_r;

  assign ten_c   = clamp_q14(tension_r);
  assign bias_c  = clamp_q14(bias_r);
  assign ft_s    = Q14_ONE_S - ten_c;
  assign fa_s    = Q14_ONE_S + bias_c;
  assign fb_s    = Q14_ONE_S - bias_c;
  assign wa_full = fa_s[FACT_W-1:0] * ft_s[FACT_W-1:0];
  assign wb_full = fb_s[FACT_W-1:0] * ft_s[FACT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wa_r <= WGT_RESET;
      wb_r <= WGT_RESET;
    end else begin
      wa_r <= wa_full[WGT_W-1:0];
      wb_r <= wb_full[WGT_W-1:0];
    end
  end

  // Pipeline control: a stage loads when it is empty or its successor loads.
  logic [NUM_STAGES:0]   rdy;
  logic [NUM_STAGES-1:0] vld_r, vld_nxt, vld_prev;
  logic                  accept;
  hsi2_ctl_t             ctl;

  always_comb begin
    rdy[NUM_STAGES] = out_rsp.ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_req.ready = rst_n && rdy[0];
  assign accept       = in_req.valid && in_req.ready;
  assign vld_prev     = {vld_r[NUM_STAGES-2:0], accept};
  assign vld_nxt      = (rdy[NUM_STAGES-1:0] & vld_prev) | (~rdy[NUM_STAGES-1:0] & vld_r);
  assign ctl.load     = rdy[NUM_STAGES-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Basis stage 1: clip t and square it.
  logic [POS_W-1:0]   t_sat, t_1_r, t_2_r;
  logic [2*POS_W-1:0] tt_nxt, tt_1_r;

  assign t_sat  = (in_req.position > POS_ONE) ? POS_ONE : in_req.position;
  assign tt_nxt = t_sat * t_sat;

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      t_1_r  <= t_sat;
      tt_1_r <= tt_nxt;
    end
  end

  // Basis stage 2: round t^2 and multiply by t again.
  logic [2*POS_W-1:0] tt_rnd, x2t_nxt, x2t_2_r;
  logic [POS_W-1:0]   x2, x2_2_r;

  assign tt_rnd  = tt_1_r + POS_HALF;
  assign x2      = tt_rnd[POS_FRAC_BITS +: POS_W];
  assign x2t_nxt = x2 * t_1_r;

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      t_2_r   <= t_1_r;
      x2_2_r  <= x2;
      x2t_2_r <= x2t_nxt;
    end
  end

  // Basis stage 3: round t^3 and form the four cubic basis weights.
  logic [2*POS_W-1:0] x2t_rnd;
  basis_t             x3e, x2e, te;
  basis_t             h00_r, h10_r, h01_r, h11_r;

  assign x2t_rnd = x2t_2_r + POS_HALF;
  assign x3e     = {2'b00, x2t_rnd[POS_FRAC_BITS +: POS_W]};
  assign x2e     = {2'b00, x2_2_r};
  assign te      = {2'b00, t_2_r};

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      h00_r <= (x3e <<< 1) - (x2e <<< 1) - x2e + H_ONE;
      h10_r <= x3e - (x2e <<< 1) + te;
      h01_r <= x3e - x2e;
      h11_r <= (x2e <<< 1) + x2e - (x3e <<< 1);
    end
  end

  // Axis datapaths.
  coord_t res_x, res_y;
  logic   sat_x, sat_y;

  hsi2_axis u_axis_x (
    .clk (clk),
    .ctl (ctl),
    .p1  (in_req.p1_x),
    .p2  (in_req.p2_x),
    .p3  (in_req.p3_x),
    .p4  (in_req.p4_x),
    .wa  (wa_r),
    .wb  (wb_r),
    .h00 (h00_r),
    .h10 (h10_r),
    .h01 (h01_r),
    .h11 (h11_r),
    .res (res_x),
    .sat (sat_x)
  );

  hsi2_axis u_axis_y (
    .clk (clk),
    .ctl (ctl),
    .p1  (in_req.p1_y),
    .p2  (in_req.p2_y),
    .p3  (in_req.p3_y),
    .p4  (in_req.p4_y),
    .wa  (wa_r),
    .wb  (wb_r),
    .h00 (h00_r),
    .h10 (h10_r),
    .h01 (h01_r),
    .h11 (h11_r),
    .res (res_y),
    .sat (sat_y)
  );

  // Result channel.
  assign out_rsp.valid     = vld_r[NUM_STAGES-1];
  assign out_rsp.out_x     = res_x;
  assign out_rsp.out_y     = res_y;
  assign out_rsp.saturated = sat_x || sat_y;

endmodule

FILE: src/hsi2_chk.sv
// Port-level checker for the Hermite spline interpolator, with its bind.
module hsi2_chk
  import hsi2_pkg::*;
(
  input logic   clk,
  input logic   rst_n,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input coord_t out_x,
  input coord_t out_y,
  input logic   saturated
);

  localparam coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // A waiting result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // A waiting result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(saturated))
    else $error("result payload changed while stalled");

  // The flag only comes with a component sitting at a range limit.
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |->
      (out_x == CMAX) || (out_x == CMIN) || (out_y == CMAX) || (out_y == CMIN))
    else $error("saturated flag without a clipped component");

  // Requests are refused only when the pipeline is backed up to the output.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("request refused with the output free");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind hermite_spline_interp_2d_unit hsi2_chk u_hsi2_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .out_x     (out_rsp.out_x),
  .out_y     (out_rsp.out_y),
  .saturated (out_rsp.saturated)
);
